>>> rtl/core/ktc_pkg.sv
// ----------------------------------------------------------------------------
// ktc_pkg: shared types and constants for the keyed TTL path cache
// Field widths, action and register codes, reset values and table entries.
// ----------------------------------------------------------------------------
`default_nettype none

package ktc_pkg;

  localparam int ACTION_W   = 3;
  localparam int COORD_W    = 6;
  localparam int KIND_W     = 8;
  localparam int RADIUS_W   = 24;
  localparam int HANDLE_W   = 16;
  localparam int FRAME_W    = 31;
  localparam int KEY_W      = 64;
  localparam int EXP_W      = 32;
  localparam int PAYLOAD_W  = HANDLE_W + 1;
  localparam int GRID_W     = 7;
  localparam int LIMIT_W    = 8;
  localparam int LIFE_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MUL_A_W    = 32;
  localparam int MUL_B_W    = 16;
  localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

  localparam int DEF_MAIN_DEPTH  = 256;
  localparam int DEF_FRAME_DEPTH = 64;
  localparam int DEF_COORD_BITS  = 6;

  localparam logic [ACTION_W-1:0] ACT_ADD_MAIN  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD_FRAME = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_PROMOTE   = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP    = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_TICK      = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_Z      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_LIMIT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIFETIME_OK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LIFETIME_FAIL = 3'd4;

  localparam logic [GRID_W-1:0]  RST_BLOCKS_X      = 7'd64;
  localparam logic [GRID_W-1:0]  RST_BLOCKS_Z      = 7'd64;
  localparam logic [LIMIT_W-1:0] RST_QUEUE_LIMIT   = 8'd200;
  localparam logic [LIFE_W-1:0]  RST_LIFETIME_OK   = 16'd180;
  localparam logic [LIFE_W-1:0]  RST_LIFETIME_FAIL = 16'd90;

  typedef struct packed {
    logic [COORD_W-1:0]  sx;
    logic [COORD_W-1:0]  sz;
    logic [COORD_W-1:0]  gx;
    logic [COORD_W-1:0]  gz;
    logic [KIND_W-1:0]   kind;
    logic [RADIUS_W-1:0] radius;
  } fields_t;

  typedef struct packed {
    logic [KEY_W-1:0]     key;
    fields_t              fields;
    logic [PAYLOAD_W-1:0] payload;
  } entry_t;

endpackage

`default_nettype wire

>>> rtl/core/ktc_req_if.sv
// ----------------------------------------------------------------------------
// ktc_req_if: request channel of the path cache
// Valid/ready channel carrying one cache operation per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ktc_req_if;
  logic                                 valid;
  logic                                 ready;
  logic [ktc_pkg::ACTION_W-1:0]         action;
  logic [ktc_pkg::COORD_W-1:0]          start_x;
  logic [ktc_pkg::COORD_W-1:0]          start_z;
  logic [ktc_pkg::COORD_W-1:0]          goal_x;
  logic [ktc_pkg::COORD_W-1:0]          goal_z;
  logic [ktc_pkg::KIND_W-1:0]           path_kind;
  logic [ktc_pkg::RADIUS_W-1:0]         goal_radius;
  logic                                 search_ok;
  logic [ktc_pkg::HANDLE_W-1:0]         path_handle;
  logic [ktc_pkg::FRAME_W-1:0]          frame_number;

  modport source (output valid, action, start_x, start_z, goal_x, goal_z, path_kind,
                  goal_radius, search_ok, path_handle, frame_number, input ready);
  modport sink   (input valid, action, start_x, start_z, goal_x, goal_z, path_kind,
                  goal_radius, search_ok, path_handle, frame_number, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ktc_rsp_if.sv
// ----------------------------------------------------------------------------
// ktc_rsp_if: response channel of the path cache
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ktc_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          hit;
  logic                          found_ok;
  logic [ktc_pkg::HANDLE_W-1:0]  found_handle;
  logic                          collision;
  logic                          dropped;

  modport source (output valid, hit, found_ok, found_handle, collision, dropped,
                  input ready);
  modport sink   (input valid, hit, found_ok, found_handle, collision, dropped,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/ktc_cfg_if.sv
// ----------------------------------------------------------------------------
// ktc_cfg_if: configuration write channel of the path cache
// Valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface ktc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ktc_pkg::CFG_IDX_W-1:0]   index;
  logic [ktc_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/keyed_ttl_cache_fifo_evict_top.sv
// ----------------------------------------------------------------------------
// keyed_ttl_cache_fifo_evict_top: two-level path handle cache with FIFO TTL
// A main table with FIFO expiry and a per-frame table, keyed by a linear key.
// Usage:
//  - req takes one operation per beat (add main, add frame, promote, lookup,
//    tick); rsp returns exactly one result beat per request; cfg writes the
//    grid size, queue limit and lifetimes and is always ready.
//  - The block handles one request at a time: req is ready only when idle,
//    the cycle after the previous result has been taken.
//  - Steps: the key takes nine products through one shared 32x16 multiplier,
//    each followed by an accumulate step, then a route step, a sweep of one
//    entry per cycle over the main table (the frame table for add frame), a
//    decide step and an insert step when an entry is stored. Add main over
//    the limit takes an evict step before its main sweep; promote adds a
//    frame sweep, a decide step and an evict step when over the limit.
//    A tick checks each expired head entry until a live one or an empty queue.
//  - The result is held in registers until rsp.ready; a stalled receiver
//    holds the block.
//  - Reset clears all valid bits and the queue at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_ttl_cache_fifo_evict_top #(
  parameter int MAIN_DEPTH  = ktc_pkg::DEF_MAIN_DEPTH,
  parameter int FRAME_DEPTH = ktc_pkg::DEF_FRAME_DEPTH,
  parameter int COORD_BITS  = ktc_pkg::DEF_COORD_BITS
) (
  input  wire clk,
  input  wire rst,
  ktc_req_if.sink   req,
  ktc_rsp_if.source rsp,
  ktc_cfg_if.sink   cfg
);

  localparam int MAW    = $clog2(MAIN_DEPTH);
  localparam int FAW    = $clog2(FRAME_DEPTH);
  localparam int CNT_W  = MAW + 1;
  localparam int SCAN_W = ((MAW > FAW) ? MAW : FAW) + 1;
  localparam int LCW    = (CNT_W > ktc_pkg::LIMIT_W) ? CNT_W : ktc_pkg::LIMIT_W;
  localparam logic [ktc_pkg::COORD_W-1:0] CMASK =
    ktc_pkg::COORD_W'((64'd1 << COORD_BITS) - 64'd1);

  typedef struct packed {
    logic [ktc_pkg::EXP_W-1:0] expiry;
    logic [MAW-1:0]            slot;
  } qent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_ROUTE, S_SCAN, S_SCAN_END, S_DECIDE,
    S_EVICT, S_INSERT, S_TK_RD, S_TK_CHK, S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [ktc_pkg::GRID_W-1:0]  blocks_x, blocks_z;
  logic [ktc_pkg::LIMIT_W-1:0] queue_limit;
  logic [ktc_pkg::LIFE_W-1:0]  lifetime_ok, lifetime_fail;

  // captured request
  logic [ktc_pkg::ACTION_W-1:0] act;
  ktc_pkg::fields_t             in_f;
  logic                         in_ok;
  logic [ktc_pkg::HANDLE_W-1:0] in_handle;
  logic [ktc_pkg::FRAME_W-1:0]  in_frame;

  // key unit
  logic [3:0]                    kstep;
  logic [ktc_pkg::MUL_A_W-1:0]   mul_a;
  logic [ktc_pkg::MUL_B_W-1:0]   mul_b;
  logic [ktc_pkg::MUL_P_W-1:0]   prod;
  logic [13:0]                   n_r, g_r;
  logic [27:0]                   n2_r;
  logic [41:0]                   n3_r;
  logic [ktc_pkg::KEY_W-1:0]     key_r;
  logic [15:0]                   rad;

  // tables
  logic [MAIN_DEPTH-1:0]  main_valid;
  logic [FRAME_DEPTH-1:0] frame_valid;
  ktc_pkg::entry_t        mmem [MAIN_DEPTH];
  ktc_pkg::entry_t        fmem [FRAME_DEPTH];
  qent_t                  qmem [MAIN_DEPTH];
  ktc_pkg::entry_t        m_rdata, f_rdata;
  qent_t                  q_rdata;
  logic [MAW-1:0]         queue_head;
  logic [CNT_W-1:0]       queue_count;

  // sweep
  logic              scan_frame;
  logic [SCAN_W-1:0] scan_i, pend_i, scan_last;
  logic              pend_v;
  logic              main_found, frame_found, main_free_v, frame_free_v;
  logic [MAW-1:0]    main_free_i;
  logic [FAW-1:0]    frame_free_i;
  ktc_pkg::entry_t   main_entry, frame_entry;
  ktc_pkg::entry_t   rd;
  logic              vbit, cmp_hit;

  // results
  logic                         r_hit, r_fok, r_coll, r_drop;
  logic [ktc_pkg::HANDLE_W-1:0] r_fh;

  // misc control
  logic                         over;
  logic                         m_we, f_we;
  ktc_pkg::entry_t              ins_entry, fr_entry;
  logic [ktc_pkg::EXP_W-1:0]    ins_exp;
  logic [CNT_W-1:0]             tsum;
  logic [MAW-1:0]               tail, head_inc, ev_slot;
  logic                         expired;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = (state == S_DONE);
  assign rsp.hit          = r_hit;
  assign rsp.found_ok     = r_fok;
  assign rsp.found_handle = r_fh;
  assign rsp.collision    = r_coll;
  assign rsp.dropped      = r_drop;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (kstep)
      4'd0: begin mul_a = 32'(blocks_x); mul_b = 16'(blocks_z); end
      4'd1: begin mul_a = 32'(blocks_x); mul_b = 16'(in_f.sz); end
      4'd2: begin mul_a = 32'(blocks_x); mul_b = 16'(in_f.gz); end
      4'd3: begin mul_a = 32'(g_r);      mul_b = 16'(n_r); end
      4'd4: begin mul_a = 32'(n_r);      mul_b = 16'(n_r); end
      4'd5: begin mul_a = 32'(n2_r);     mul_b = 16'(in_f.kind); end
      4'd6: begin mul_a = 32'(n2_r);     mul_b = 16'(n_r); end
      4'd7: begin mul_a = n3_r[31:0];    mul_b = rad; end
      4'd8: begin mul_a = 32'(n3_r[41:32]); mul_b = rad; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign rad = (in_f.radius[23:8] == 16'd0) ? 16'd1 : in_f.radius[23:8];

  assign over = ({{(LCW-CNT_W){1'b0}}, queue_count} >
                 {{(LCW-ktc_pkg::LIMIT_W){1'b0}}, queue_limit}) ||
                (queue_count >= CNT_W'(MAIN_DEPTH));

  assign tsum     = CNT_W'(queue_head) + queue_count;
  assign tail     = (tsum >= CNT_W'(MAIN_DEPTH)) ? MAW'(tsum - CNT_W'(MAIN_DEPTH))
                                                 : tsum[MAW-1:0];
  assign head_inc = (queue_head == MAW'(MAIN_DEPTH - 1)) ? '0 : queue_head + 1'b1;
  assign ev_slot  = q_rdata.slot;
  assign expired  = q_rdata.expiry < {1'b0, in_frame};

  assign scan_last = scan_frame ? SCAN_W'(FRAME_DEPTH - 1) : SCAN_W'(MAIN_DEPTH - 1);
  assign rd        = scan_frame ? f_rdata : m_rdata;
  assign vbit      = scan_frame ? frame_valid[pend_i[FAW-1:0]]
                                : main_valid[pend_i[MAW-1:0]];
  assign cmp_hit   = vbit && (rd.key == key_r);

  assign fr_entry = '{key: key_r, fields: in_f, payload: {in_ok, in_handle}};
  assign ins_entry = (act == ktc_pkg::ACT_PROMOTE)
    ? '{key: key_r, fields: frame_entry.fields, payload: frame_entry.payload}
    : fr_entry;
  assign ins_exp = {1'b0, in_frame} +
                   32'(in_ok ? lifetime_ok : lifetime_fail);

  assign m_we = (state == S_INSERT) && main_free_v &&
                (queue_count < CNT_W'(MAIN_DEPTH));
  assign f_we = (state == S_DECIDE) && (act == ktc_pkg::ACT_ADD_FRAME) &&
                !frame_found && frame_free_v;

  // table memories: registered reads
  always_ff @(posedge clk) begin
    if (m_we) begin
      mmem[main_free_i] <= ins_entry;
      qmem[tail]        <= '{expiry: ins_exp, slot: main_free_i};
    end
    if (f_we) begin
      fmem[frame_free_i] <= fr_entry;
    end
    m_rdata <= mmem[scan_i[MAW-1:0]];
    f_rdata <= fmem[scan_i[FAW-1:0]];
    // head entry is read every cycle; valid in the cycle after head moves
    q_rdata <= qmem[queue_head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      blocks_x      <= ktc_pkg::RST_BLOCKS_X;
      blocks_z      <= ktc_pkg::RST_BLOCKS_Z;
      queue_limit   <= ktc_pkg::RST_QUEUE_LIMIT;
      lifetime_ok   <= ktc_pkg::RST_LIFETIME_OK;
      lifetime_fail <= ktc_pkg::RST_LIFETIME_FAIL;
      main_valid    <= '0;
      frame_valid   <= '0;
      queue_head    <= '0;
      queue_count   <= '0;
      kstep         <= '0;
      pend_v        <= 1'b0;
      scan_frame    <= 1'b0;
      scan_i        <= '0;
      main_found    <= 1'b0;
      frame_found   <= 1'b0;
      main_free_v   <= 1'b0;
      frame_free_v  <= 1'b0;
      r_hit         <= 1'b0;
      r_fok         <= 1'b0;
      r_fh          <= '0;
      r_coll        <= 1'b0;
      r_drop        <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          ktc_pkg::REG_BLOCKS_X:      blocks_x      <= cfg.data[ktc_pkg::GRID_W-1:0];
          ktc_pkg::REG_BLOCKS_Z:      blocks_z      <= cfg.data[ktc_pkg::GRID_W-1:0];
          ktc_pkg::REG_QUEUE_LIMIT:   queue_limit   <= cfg.data[ktc_pkg::LIMIT_W-1:0];
          ktc_pkg::REG_LIFETIME_OK:   lifetime_ok   <= cfg.data;
          ktc_pkg::REG_LIFETIME_FAIL: lifetime_fail <= cfg.data;
          default: ;
        endcase
      end

      // compare stage of the sweep
      if (pend_v) begin
        if (scan_frame) begin
          if (cmp_hit && !frame_found) begin
            frame_found <= 1'b1;
            frame_entry <= rd;
          end
          if (!vbit && !frame_free_v) begin
            frame_free_v <= 1'b1;
            frame_free_i <= pend_i[FAW-1:0];
          end
        end else begin
          if (cmp_hit && !main_found) begin
            main_found <= 1'b1;
            main_entry <= rd;
          end
          if (!vbit && !main_free_v) begin
            main_free_v <= 1'b1;
            main_free_i <= pend_i[MAW-1:0];
          end
        end
      end

      case (state)
        S_IDLE: begin
          if (req.valid) begin
            act       <= req.action;
            in_f.sx   <= req.start_x & CMASK;
            in_f.sz   <= req.start_z & CMASK;
            in_f.gx   <= req.goal_x & CMASK;
            in_f.gz   <= req.goal_z & CMASK;
            in_f.kind <= req.path_kind;
            in_f.radius <= req.goal_radius;
            in_ok     <= req.search_ok;
            in_handle <= req.path_handle;
            in_frame  <= req.frame_number;
            r_hit     <= 1'b0;
            r_fok     <= 1'b0;
            r_fh      <= '0;
            r_coll    <= 1'b0;
            r_drop    <= 1'b0;
            kstep     <= '0;
            if (req.action == ktc_pkg::ACT_TICK) begin
              state <= S_TK_RD;
            end else if (req.action > ktc_pkg::ACT_TICK) begin
              state <= S_DONE;
            end else begin
              state <= S_MUL;
            end
          end
        end

        S_MUL: begin
          prod  <= ktc_pkg::MUL_P_W'(mul_a) * ktc_pkg::MUL_P_W'(mul_b);
          state <= S_ACC;
        end

        S_ACC: begin
          case (kstep)
            4'd0: n_r   <= prod[13:0];
            4'd1: key_r <= 64'(prod) + 64'(in_f.sx);
            4'd2: g_r   <= prod[13:0] + 14'(in_f.gx);
            4'd3: key_r <= key_r + 64'(prod);
            4'd4: n2_r  <= prod[27:0];
            4'd5: key_r <= key_r + 64'(prod);
            4'd6: n3_r  <= prod[41:0];
            4'd7: key_r <= key_r + 64'(prod);
            4'd8: key_r <= key_r + {prod[31:0], 32'd0};
            default: ;
          endcase
          kstep <= kstep + 4'd1;
          state <= (kstep == 4'd8) ? S_ROUTE : S_MUL;
        end

        S_ROUTE: begin
          if (act == ktc_pkg::ACT_ADD_MAIN && over) begin
            state <= S_EVICT;
          end else begin
            scan_frame <= (act == ktc_pkg::ACT_ADD_FRAME);
            scan_i     <= '0;
            if (act == ktc_pkg::ACT_ADD_FRAME) begin
              frame_found  <= 1'b0;
              frame_free_v <= 1'b0;
            end else begin
              main_found  <= 1'b0;
              main_free_v <= 1'b0;
            end
            state <= S_SCAN;
          end
        end

        S_SCAN: begin
          pend_v <= 1'b1;
          pend_i <= scan_i;
          scan_i <= scan_i + 1'b1;
          if (scan_i == scan_last) begin
            state <= S_SCAN_END;
          end
        end

        S_SCAN_END: begin
          pend_v <= 1'b0;
          state  <= S_DECIDE;
        end

        S_DECIDE: begin
          case (act)
            ktc_pkg::ACT_ADD_MAIN: begin
              if (main_found) begin
                r_coll <= (main_entry.fields != in_f);
                state  <= S_DONE;
              end else begin
                state <= S_INSERT;
              end
            end
            ktc_pkg::ACT_ADD_FRAME: begin
              if (!frame_found && !frame_free_v) begin
                r_drop <= 1'b1;
              end
              if (f_we) begin
                frame_valid[frame_free_i] <= 1'b1;
              end
              state <= S_DONE;
            end
            ktc_pkg::ACT_PROMOTE: begin
              if (!scan_frame) begin
                if (main_found) begin
                  state <= S_DONE;
                end else begin
                  // keep the main free slot, sweep the frame table next
                  scan_frame   <= 1'b1;
                  scan_i       <= '0;
                  frame_found  <= 1'b0;
                  frame_free_v <= 1'b0;
                  state        <= S_SCAN;
                end
              end else if (!frame_found) begin
                state <= S_DONE;
              end else begin
                state <= over ? S_EVICT : S_INSERT;
              end
            end
            ktc_pkg::ACT_LOOKUP: begin
              if (main_found &&
                  main_entry.fields.sx == in_f.sx && main_entry.fields.sz == in_f.sz &&
                  main_entry.fields.gx == in_f.gx && main_entry.fields.gz == in_f.gz &&
                  main_entry.fields.kind == in_f.kind) begin
                r_hit <= 1'b1;
                r_fok <= main_entry.payload[ktc_pkg::HANDLE_W];
                r_fh  <= main_entry.payload[ktc_pkg::HANDLE_W-1:0];
              end
              state <= S_DONE;
            end
            default: state <= S_DONE;
          endcase
        end

        S_EVICT: begin
          if (queue_count != '0) begin
            main_valid[ev_slot] <= 1'b0;
            queue_head  <= head_inc;
            queue_count <= queue_count - 1'b1;
            // a freed slot may now be the lowest free one
            if (act != ktc_pkg::ACT_ADD_MAIN &&
                (!main_free_v || ev_slot < main_free_i)) begin
              main_free_v <= 1'b1;
              main_free_i <= ev_slot;
            end
          end
          if (act == ktc_pkg::ACT_ADD_MAIN) begin
            scan_frame  <= 1'b0;
            scan_i      <= '0;
            main_found  <= 1'b0;
            main_free_v <= 1'b0;
            state       <= S_SCAN;
          end else begin
            state <= S_INSERT;
          end
        end

        S_INSERT: begin
          if (m_we) begin
            main_valid[main_free_i] <= 1'b1;
            queue_count <= queue_count + 1'b1;
          end
          state <= S_DONE;
        end

        S_TK_RD: begin
          if (queue_count == '0) begin
            frame_valid <= '0;
            state       <= S_DONE;
          end else begin
            state <= S_TK_CHK;
          end
        end

        S_TK_CHK: begin
          if (expired) begin
            main_valid[ev_slot] <= 1'b0;
            queue_head  <= head_inc;
            queue_count <= queue_count - 1'b1;
            state       <= S_TK_RD;
          end else begin
            frame_valid <= '0;
            state       <= S_DONE;
          end
        end

        S_DONE: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
